FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbf assertion failed");

// property checked on every clock edge, reset included
`define LBF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lbf assertion failed");

`endif

FILE: src/lbf_pkg.sv
// shared types and constants of the learning bridge forwarding block
package lbf_pkg;

  localparam int unsigned ADDR_W          = 48;
  localparam int unsigned PORT_W          = 2;
  localparam int unsigned MASK_W          = 4;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned NUM_ADDR_REGS   = 4;
  localparam int unsigned PORT_COUNT      = 4;
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam int unsigned USABLE_COUNT =
    (PORT_COUNT < NUM_ADDR_REGS) ? PORT_COUNT : NUM_ADDR_REGS;
  localparam logic [MASK_W-1:0] USABLE_PORTS = MASK_W'((1 << USABLE_COUNT) - 1);

  typedef enum logic [2:0] {
    DEC_LOCAL      = 3'd0,
    DEC_LEARNED    = 3'd1,
    DEC_FLOOD      = 3'd2,
    DEC_PORT_DOWN  = 3'd3,
    DEC_OWN_SOURCE = 3'd4,
    DEC_OWN_DEST   = 3'd5,
    DEC_SAME_PORT  = 3'd6
  } decision_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PORT0_ADDR   = 3'd0,
    CFG_PORT1_ADDR   = 3'd1,
    CFG_PORT2_ADDR   = 3'd2,
    CFG_PORT3_ADDR   = 3'd3,
    CFG_PRESENT_MASK = 3'd4,
    CFG_UP_MASK      = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_LEARN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic learn;
    logic res_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic count_zero;
    logic issue_last;
  } dp_status_t;

endpackage

FILE: src/lbf_ram.sv
// generic single write port ram with registered read
module lbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/lbf_ctrl.sv
// controller state machine: sequences check, table scan, learning and result
module lbf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lbf_pkg::dp_status_t status,
  output lbf_pkg::dp_cmd_t    cmd
);

  import lbf_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (status.drop) state_nxt = ST_FINISH;
        else if (status.count_zero) state_nxt = ST_LEARN;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.issue_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_LEARN;
      ST_LEARN:  state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_CHECK: begin
        cmd.scan_start = 1'b1;
        cmd.res_load   = status.drop;
      end
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DRAIN:  cmd = '0;
      ST_LEARN: begin
        cmd.learn    = 1'b1;
        cmd.res_load = 1'b1;
      end
      ST_FINISH: cmd.out_load = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/lbf_dp.sv
// datapath: port registers, address table, scan compare and decision logic
module lbf_dp #(
  parameter int unsigned TABLE_DEPTH = lbf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbf_pkg::ADDR_W-1:0]     cfg_wr_data,
  input  logic [lbf_pkg::PORT_W-1:0]     in_ingress_port,
  input  logic [lbf_pkg::ADDR_W-1:0]     in_source_address,
  input  logic [lbf_pkg::ADDR_W-1:0]     in_destination_address,
  input  lbf_pkg::dp_cmd_t               cmd,
  output lbf_pkg::dp_status_t            status,
  output logic [2:0]                     out_decision,
  output logic [lbf_pkg::MASK_W-1:0]     out_egress_mask,
  output logic                           out_source_learned,
  output logic                           out_table_full
);

  import lbf_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W = ADDR_W + PORT_W;

  // port configuration
  logic [ADDR_W-1:0] port_addr_r [NUM_ADDR_REGS];
  logic [MASK_W-1:0] present_r;
  logic [MASK_W-1:0] up_r;

  // latched frame header
  logic [PORT_W-1:0] ingress_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] dst_r;

  // table fill count and scan state
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic              src_hit_r;
  logic [IDX_W-1:0]  src_idx_r;
  logic              dst_hit_r;
  logic [PORT_W-1:0] dst_port_r;

  // result staging and output registers
  decision_t         res_dec_r;
  logic [MASK_W-1:0] res_egress_r;
  logic              res_learned_r;
  logic              res_full_r;
  decision_t         out_dec_r;
  logic [MASK_W-1:0] out_egress_r;
  logic              out_learned_r;
  logic              out_full_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [ADDR_W-1:0]  rd_key;
  logic [PORT_W-1:0]  rd_port;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;

  logic [MASK_W-1:0] present_eff;
  logic [MASK_W-1:0] up_eff;
  logic [ADDR_W-1:0] own_addr;
  logic              port_down;
  logic              own_src;
  logic              learn_ok;
  logic              same_addr;
  logic              dst_hit_eff;
  logic [PORT_W-1:0] dst_port_eff;

  decision_t         res_dec;
  logic [MASK_W-1:0] res_egress;
  logic              res_learned;
  logic              res_full;
  logic              local_hit;
  logic [MASK_W-1:0] local_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_ADDR_REGS; p++) begin
        port_addr_r[p] <= '0;
      end
      present_r <= '0;
      up_r      <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PORT0_ADDR:   port_addr_r[0] <= cfg_wr_data;
        CFG_PORT1_ADDR:   port_addr_r[1] <= cfg_wr_data;
        CFG_PORT2_ADDR:   port_addr_r[2] <= cfg_wr_data;
        CFG_PORT3_ADDR:   port_addr_r[3] <= cfg_wr_data;
        CFG_PRESENT_MASK: present_r      <= cfg_wr_data[MASK_W-1:0];
        CFG_UP_MASK:      up_r           <= cfg_wr_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ingress_r <= in_ingress_port;
      src_r     <= in_source_address;
      dst_r     <= in_destination_address;
    end
  end

  assign present_eff = present_r & USABLE_PORTS;
  assign up_eff      = up_r & USABLE_PORTS;
  assign own_addr    = port_addr_r[ingress_r];
  assign port_down   = !up_eff[ingress_r];
  assign own_src     = (src_r == own_addr);

  assign status.drop       = port_down || own_src;
  assign status.count_zero = (count_r == '0);
  assign status.issue_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r);

  // table: key in the low bits, learned port above it
  assign rd_key  = rd_data[ADDR_W-1:0];
  assign rd_port = rd_data[ENTRY_W-1:ADDR_W];

  // entries below the fill count are valid, so a new source goes at the count
  assign learn_ok    = src_hit_r || (count_r != CNT_W'(TABLE_DEPTH));
  assign ram_wr_en   = cmd.learn && learn_ok;
  assign ram_wr_addr = src_hit_r ? src_idx_r : count_r[IDX_W-1:0];

  lbf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data ({ingress_r, src_r}),
    .rd_en   (cmd.scan_step),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      cmp_vld_r  <= 1'b0;
      src_hit_r  <= 1'b0;
      dst_hit_r  <= 1'b0;
      scan_idx_r <= '0;
    end else if (cmd.scan_start) begin
      cmp_vld_r  <= 1'b0;
      src_hit_r  <= 1'b0;
      dst_hit_r  <= 1'b0;
      scan_idx_r <= '0;
    end else begin
      cmp_vld_r <= cmd.scan_step;
      if (cmd.scan_step) begin
        cmp_idx_r  <= scan_idx_r;
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      // read data arrives in the cycle after its address is issued
      if (cmp_vld_r && !src_hit_r && (rd_key == src_r)) begin
        src_hit_r <= 1'b1;
        src_idx_r <= cmp_idx_r;
      end
      if (cmp_vld_r && !dst_hit_r && (rd_key == dst_r)) begin
        dst_hit_r  <= 1'b1;
        dst_port_r <= rd_port;
      end
      if (cmd.learn && learn_ok && !src_hit_r) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  // source is learned before the destination lookup, so it wins on a match
  assign same_addr    = (src_r == dst_r) && learn_ok;
  assign dst_hit_eff  = dst_hit_r || same_addr;
  assign dst_port_eff = same_addr ? ingress_r : dst_port_r;

  always_comb begin
    res_dec     = DEC_FLOOD;
    res_egress  = '0;
    res_learned = 1'b0;
    res_full    = 1'b0;
    local_hit   = 1'b0;
    local_mask  = '0;
    // lowest present port that owns the destination
    for (int p = 0; p < NUM_ADDR_REGS; p++) begin
      if (!local_hit && present_eff[p] && (dst_r == port_addr_r[p])) begin
        local_hit  = 1'b1;
        local_mask = MASK_W'(1) << p;
      end
    end
    priority if (port_down) begin
      res_dec = DEC_PORT_DOWN;
    end else if (own_src) begin
      res_dec = DEC_OWN_SOURCE;
    end else begin
      res_learned = learn_ok;
      res_full    = !learn_ok;
      priority if (dst_r == own_addr) begin
        res_dec = DEC_OWN_DEST;
      end else if (local_hit) begin
        res_dec    = DEC_LOCAL;
        res_egress = local_mask;
      end else if (dst_hit_eff) begin
        if (dst_port_eff == ingress_r) begin
          res_dec = DEC_SAME_PORT;
        end else begin
          res_dec    = DEC_LEARNED;
          res_egress = MASK_W'(1) << dst_port_eff;
        end
      end else begin
        res_dec    = DEC_FLOOD;
        res_egress = present_eff & ~(MASK_W'(1) << ingress_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_dec_r     <= res_dec;
      res_egress_r  <= res_egress;
      res_learned_r <= res_learned;
      res_full_r    <= res_full;
    end
    if (cmd.out_load) begin
      out_dec_r     <= res_dec_r;
      out_egress_r  <= res_egress_r;
      out_learned_r <= res_learned_r;
      out_full_r    <= res_full_r;
    end
  end

  assign out_decision       = out_dec_r;
  assign out_egress_mask    = out_egress_r;
  assign out_source_learned = out_learned_r;
  assign out_table_full     = out_full_r;

endmodule

FILE: src/learning_bridge_forwarding.sv
// top level of the learning bridge forwarding block
// One frame header per item gives one forwarding decision. The address table
// sits in a single-port-read ram that is scanned one entry per cycle. An item
// passes check, a scan of the learned addresses (at most TABLE_DEPTH), drain,
// learn and finish before the next item is accepted; an empty table skips
// scan and drain, and a frame dropped for a down port or its own source goes
// from check straight to finish. Entries are filled in order and never
// removed, so a fill count marks the valid part of the table and no clearing
// pass runs after reset. A finished result waits in an output register while
// the next item is taken in; while that register is still stalled, the next
// result holds in the last state and the input stays stalled. The user writes
// port registers only while no item is in flight; the block does not check it.
module learning_bridge_forwarding #(
  parameter int unsigned TABLE_DEPTH = lbf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbf_pkg::ADDR_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lbf_pkg::PORT_W-1:0]     in_ingress_port,
  input  logic [lbf_pkg::ADDR_W-1:0]     in_source_address,
  input  logic [lbf_pkg::ADDR_W-1:0]     in_destination_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_decision,
  output logic [lbf_pkg::MASK_W-1:0]     out_egress_mask,
  output logic                           out_source_learned,
  output logic                           out_table_full
);

  import lbf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lbf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wr_data            (cfg_wr_data),
    .in_ingress_port        (in_ingress_port),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .cmd                    (cmd),
    .status                 (status),
    .out_decision           (out_decision),
    .out_egress_mask        (out_egress_mask),
    .out_source_learned     (out_source_learned),
    .out_table_full         (out_table_full)
  );

endmodule

FILE: src/lbf_checker.sv
// port-level checker for the learning bridge forwarding block and its bind
`include "assert_macros.svh"

module lbf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [2:0]                 out_decision,
  input logic [lbf_pkg::MASK_W-1:0] out_egress_mask,
  input logic                       out_source_learned,
  input logic                       out_table_full
);

  import lbf_pkg::*;

  logic early_drop_dec;
  logic quiet_result;
  logic unicast_dec;

  assign early_drop_dec = (out_decision == DEC_PORT_DOWN) || (out_decision == DEC_OWN_SOURCE);
  assign quiet_result   = (out_egress_mask == '0) && !out_source_learned && !out_table_full;
  assign unicast_dec    = (out_decision == DEC_LOCAL) || (out_decision == DEC_LEARNED);

  // a waiting result is not withdrawn
  `LBF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)

  // an accepted item keeps the input side busy while it is worked on
  `LBF_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)

  // early drops send nowhere and never touch the table
  `LBF_ASSERT(a_early_drop, clk, rst_n, out_valid && early_drop_dec |-> quiet_result)

  // unicast decisions go to exactly one port
  `LBF_ASSERT(a_unicast_onehot, clk, rst_n, out_valid && unicast_dec |-> $onehot(out_egress_mask))

  `LBF_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind learning_bridge_forwarding lbf_checker u_lbf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_decision       (out_decision),
  .out_egress_mask    (out_egress_mask),
  .out_source_learned (out_source_learned),
  .out_table_full     (out_table_full)
);

FILE: verif/testbench.sv
// self-checking testbench for the learning bridge forwarding block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbf_pkg::*;

  localparam int unsigned ENTRIES = TABLE_DEPTH_DEF;
  localparam int unsigned POOL_SIZE = 40;
  localparam int unsigned PHASES = 7;
  // one full table scan plus margin for the other steps of an item
  localparam int unsigned DRAIN_CYCLES = ENTRIES + 8;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam bit SENDER = 1'b0;
  localparam bit RECEIVER = 1'b1;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } header_t;

  typedef struct packed {
    decision_t         decision;
    logic [MASK_W-1:0] egress;
    logic              learned;
    logic              full;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PORT_W-1:0]    in_ingress_port = '0;
  logic [ADDR_W-1:0]    in_source_address = '0;
  logic [ADDR_W-1:0]    in_destination_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           out_decision;
  logic [MASK_W-1:0]    out_egress_mask;
  logic                 out_source_learned;
  logic                 out_table_full;

  // shadow of the block's registers and address table
  logic [ADDR_W-1:0] port_addr [NUM_ADDR_REGS];
  logic [MASK_W-1:0] present_mask = '0;
  logic [MASK_W-1:0] up_mask = '0;
  logic [ADDR_W-1:0] learned_key [ENTRIES];
  logic [PORT_W-1:0] learned_port [ENTRIES];
  bit                learned_valid [ENTRIES];

  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  header_t  pending_headers [$];
  verdict_t predicted_verdicts [$];
  header_t  current_header;

  int unsigned headers_queued = 0;
  int unsigned headers_accepted = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_count = 0;
  int unsigned full_hits = 0;
  int unsigned decision_hits [7];
  int          calm_left [2];
  int          send_gap = 0;
  int          stall_left = 0;

  learning_bridge_forwarding uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_ingress_port        (in_ingress_port),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_decision           (out_decision),
    .out_egress_mask        (out_egress_mask),
    .out_source_learned     (out_source_learned),
    .out_table_full         (out_table_full)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [ADDR_W-1:0] random_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int idle_length(bit side);
    int roll;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      calm_left[side] = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int find_slot(logic [ADDR_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (learned_valid[i] && learned_key[i] == key) return i;
    end
    return -1;
  endfunction

  // forwarding decision for one header; learns the source as a side effect
  function automatic verdict_t forward_decision(header_t h);
    logic [MASK_W-1:0] present;
    logic [MASK_W-1:0] up;
    verdict_t          v;
    int                slot;
    int                local_hit;
    present = present_mask & USABLE_PORTS;
    up = up_mask & USABLE_PORTS;
    v.decision = DEC_FLOOD;
    v.egress = '0;
    v.learned = 1'b0;
    v.full = 1'b0;
    if (!up[h.port]) begin
      v.decision = DEC_PORT_DOWN;
      return v;
    end
    if (h.src == port_addr[h.port]) begin
      v.decision = DEC_OWN_SOURCE;
      return v;
    end
    slot = find_slot(h.src);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && !learned_valid[i]) slot = i;
    end
    if (slot >= 0) begin
      learned_key[slot] = h.src;
      learned_port[slot] = h.port;
      learned_valid[slot] = 1'b1;
      v.learned = 1'b1;
    end else begin
      v.full = 1'b1;
    end
    if (h.dst == port_addr[h.port]) begin
      v.decision = DEC_OWN_DEST;
      return v;
    end
    // lowest present port wins when addresses are shared
    local_hit = -1;
    for (int p = NUM_ADDR_REGS - 1; p >= 0; p--) begin
      if (present[p] && h.dst == port_addr[p]) local_hit = p;
    end
    if (local_hit >= 0) begin
      v.decision = DEC_LOCAL;
      v.egress = MASK_W'(1) << local_hit;
      return v;
    end
    slot = find_slot(h.dst);
    if (slot >= 0) begin
      if (learned_port[slot] == h.port) begin
        v.decision = DEC_SAME_PORT;
      end else begin
        v.decision = DEC_LEARNED;
        v.egress = MASK_W'(1) << learned_port[slot];
      end
      return v;
    end
    v.egress = present & ~(MASK_W'(1) << h.port);
    return v;
  endfunction

  function automatic header_t random_header(bit fresh_sources);
    header_t h;
    int      roll;
    h.port = PORT_W'($urandom_range(0, 3));
    roll = $urandom_range(0, 99);
    if (roll < 8) h.src = port_addr[h.port];
    else if (roll < 12) h.src = port_addr[$urandom_range(0, NUM_ADDR_REGS - 1)];
    else if (fresh_sources && roll < 30) h.src = random_address();
    else h.src = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 15) h.dst = port_addr[$urandom_range(0, NUM_ADDR_REGS - 1)];
    else if (roll < 25) h.dst = h.src;
    else if (roll < 35) h.dst = random_address();
    else h.dst = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return h;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_port_address(int p);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 30) return ALL_ONES;
    if (roll < 45 && p > 0) return port_addr[$urandom_range(0, p - 1)];
    if (roll < 65) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return random_address();
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wr_data <= value;
    case (index)
      CFG_PORT0_ADDR:   port_addr[0] = value;
      CFG_PORT1_ADDR:   port_addr[1] = value;
      CFG_PORT2_ADDR:   port_addr[2] = value;
      CFG_PORT3_ADDR:   port_addr[3] = value;
      CFG_PRESENT_MASK: present_mask = value[MASK_W-1:0];
      CFG_UP_MASK:      up_mask = value[MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_settings(input logic [MASK_W-1:0] present,
                                input logic [MASK_W-1:0] up);
    logic [ADDR_W-1:0] noise;
    write_register(CFG_PORT0_ADDR, pick_port_address(0));
    write_register(CFG_PORT1_ADDR, pick_port_address(1));
    write_register(CFG_PORT2_ADDR, pick_port_address(2));
    write_register(CFG_PORT3_ADDR, pick_port_address(3));
    // upper data bits of the mask registers must be ignored
    noise = random_address();
    write_register(CFG_PRESENT_MASK, {noise[ADDR_W-1:MASK_W], present});
    noise = random_address();
    write_register(CFG_UP_MASK, {noise[ADDR_W-1:MASK_W], up});
    write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, random_address());
    settings_count++;
  endtask

  task automatic queue_header(input logic [PORT_W-1:0] port,
                              input logic [ADDR_W-1:0] src,
                              input logic [ADDR_W-1:0] dst);
    header_t h;
    h.port = port;
    h.src = src;
    h.dst = dst;
    pending_headers.push_back(h);
    headers_queued++;
  endtask

  task automatic wait_drained();
    while (headers_accepted < headers_queued || predicted_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // input side: sample the handshake at the rising edge, drive at the falling edge
  always begin : feed_headers
    bit taken;
    @(posedge clk);
    taken = rst_n && in_valid && !in_stall;
    if (taken) begin
      predicted_verdicts.push_back(forward_decision(current_header));
      headers_accepted++;
    end
    @(negedge clk);
    if (in_valid && !taken) begin
      // stalled item stays on the bus
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (rst_n && pending_headers.size() > 0) begin
      current_header = pending_headers.pop_front();
      in_ingress_port <= current_header.port;
      in_source_address <= current_header.src;
      in_destination_address <= current_header.dst;
      in_valid <= 1'b1;
      send_gap = idle_length(SENDER);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side: compare accepted results, then pick the next stall
  always begin : check_verdicts
    verdict_t want;
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_verdicts.size() == 0) begin
        $error("result with no item pending");
        failures++;
      end else begin
        want = predicted_verdicts.pop_front();
        decision_hits[int'(want.decision)]++;
        if (want.full) full_hits++;
        if (out_decision !== want.decision) begin
          $error("decision: expected %0d, got %0d", want.decision, out_decision);
          failures++;
        end
        if (out_egress_mask !== want.egress) begin
          $error("egress_mask: expected %b, got %b", want.egress, out_egress_mask);
          failures++;
        end
        if (out_source_learned !== want.learned) begin
          $error("source_learned: expected %0d, got %0d", want.learned, out_source_learned);
          failures++;
        end
        if (out_table_full !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, out_table_full);
          failures++;
        end
      end
    end
    @(negedge clk);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_length(RECEIVER);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit with %0d results outstanding",
             predicted_verdicts.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] shared;
    logic [MASK_W-1:0] present_plan [PHASES];
    logic [MASK_W-1:0] up_plan [PHASES];
    header_t           h;
    int                burst;
    for (int i = 0; i < NUM_ADDR_REGS; i++) port_addr[i] = '0;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = random_address();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: every port is down
    queue_header(2'd0, '0, '0);
    queue_header(2'd3, ALL_ONES, ALL_ONES);
    wait_drained();

    write_register(CFG_PORT0_ADDR, '0);
    write_register(CFG_PORT1_ADDR, 48'h0000_0000_0011);
    write_register(CFG_PORT2_ADDR, 48'h0000_0000_0022);
    write_register(CFG_PORT3_ADDR, ALL_ONES);
    write_register(CFG_PRESENT_MASK, {44'hFFF_FFFF_FFFF, 4'hF});
    write_register(CFG_UP_MASK, 48'hF);
    write_register(CFG_SPARE_HI, ALL_ONES);
    settings_count += 2;
    queue_header(2'd0, '0, 48'h5);                             // own source, zero address
    queue_header(2'd3, ALL_ONES, 48'h5);                       // own source, all ones
    queue_header(2'd1, 48'hA5A5_0000_0001, 48'hA5A5_0000_0001); // source is destination
    queue_header(2'd2, 48'h5A5A_FFFF_0002, 48'hA5A5_0000_0001); // learned unicast
    queue_header(2'd2, 48'h5A5A_FFFF_0002, ALL_ONES);          // local port 3
    queue_header(2'd1, 48'hA5A5_0000_0001, 48'h0000_0000_0011); // own destination
    queue_header(2'd1, 48'h0123_4567_89AB, '0);                // local port 0
    queue_header(2'd3, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFE); // unknown: flood
    queue_header(2'd3, 48'hA5A5_0000_0001, 48'h5A5A_FFFF_0002); // station moves to port 3
    queue_header(2'd0, 48'h5A5A_FFFF_0002, 48'hA5A5_0000_0001);
    queue_header(2'd0, 48'h0123_4567_89AB, 48'h5A5A_FFFF_0002); // learned on ingress
    wait_drained();

    // shared address on ports 1 and 2, port 0 absent, ports 1 and 2 down
    shared = 48'h0000_1234_5678;
    write_register(CFG_PORT0_ADDR, ALL_ONES);
    write_register(CFG_PORT1_ADDR, shared);
    write_register(CFG_PORT2_ADDR, shared);
    write_register(CFG_PORT3_ADDR, '0);
    write_register(CFG_PRESENT_MASK, 48'hE);
    write_register(CFG_UP_MASK, 48'h9);
    write_register(CFG_SPARE_LO, 48'h3);
    queue_header(2'd2, 48'h0F0F_0F0F_0F0F, 48'hF0F0_F0F0_F0F0); // port down
    queue_header(2'd0, 48'h0F0F_0F0F_0F0F, shared);            // lowest port, which is down
    queue_header(2'd3, 48'hF0F0_F0F0_F0F0, ALL_ONES);          // absent port address: flood
    queue_header(2'd3, 48'h0F0F_0F0F_0F0F, '0);                // own destination
    queue_header(2'd0, 48'hF0F0_F0F0_F0F0, 48'h0F0F_0F0F_0F0F);
    queue_header(2'd0, ALL_ONES, 48'h0F0F_0F0F_0F0F);          // own source on absent port
    wait_drained();

    present_plan = '{4'hF, 4'hF, MASK_W'($urandom), 4'h0, 4'hF, MASK_W'($urandom), 4'hF};
    up_plan = '{4'hF, MASK_W'($urandom), 4'hF, 4'hF, MASK_W'($urandom), 4'hF, 4'h0};
    // the first phases reuse a small address pool; later ones add new sources
    // until the table overflows
    for (int phase = 0; phase < PHASES; phase++) begin
      apply_settings(present_plan[phase], up_plan[phase]);
      burst = (up_plan[phase] == '0) ? 40 : 240;
      for (int i = 0; i < burst; i++) begin
        h = random_header(phase >= 3);
        queue_header(h.port, h.src, h.dst);
      end
      wait_drained();
    end

    $display("%0d frame headers over %0d register settings in %0d cycles",
             headers_accepted, settings_count, cycle_count);
    $write("local %0d, learned %0d, flood %0d, down %0d, ",
           decision_hits[DEC_LOCAL], decision_hits[DEC_LEARNED],
           decision_hits[DEC_FLOOD], decision_hits[DEC_PORT_DOWN]);
    $display("own src %0d, own dst %0d, same %0d, full %0d",
             decision_hits[DEC_OWN_SOURCE], decision_hits[DEC_OWN_DEST],
             decision_hits[DEC_SAME_PORT], full_hits);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
